// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files that carry checks.
// No dependencies; each file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every clock edge outside reset.
`define AST_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ert_pkg.sv =====
// Shared types, constants and helpers of the epoch reclamation tracker.
// No dependencies; used by ert_ctrl, ert_dpath and epoch_reclamation_tracker.
`timescale 1ns / 1ps

package ert_pkg;

  localparam int THREADS    = 64;
  localparam int SLOT_W     = 6;
  localparam int SLOTS      = 1 << SLOT_W;
  localparam int EPOCH_W    = 64;
  localparam int CNT_W      = 16;
  localparam int BAG_W      = 2;
  localparam int BAG_COUNT  = 3;
  localparam int EPOCH_STEP = 2;
  localparam int CFG_W      = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    ACT_REGISTER   = 2'd0,
    ACT_UNREGISTER = 2'd1,
    ACT_ENTER      = 2'd2,
    ACT_LEAVE      = 2'd3
  } act_t;

  typedef enum logic [0:0] {
    REG_CHECK_THR = 1'b0,
    REG_ADV_THR   = 1'b1
  } cfg_idx_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // latch request, read caller's entries
    logic rd_other;  // read the examined slot's announcement
    logic exec;      // update state, register the result
  } ert_cmd_t;

  // Per-slot counters kept in one memory word.
  typedef struct packed {
    logic [BAG_W-1:0] bag;
    logic [CNT_W-1:0] op;
    logic [CNT_W-1:0] scan;
  } rec_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

// ===== rtl/ert_ctrl.sv =====
// Controller of the epoch reclamation tracker: sequences one request
// through read, examine and update. Depends on ert_pkg.
`timescale 1ns / 1ps

module ert_ctrl import ert_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output ert_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_EXEC = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_READ;
      end
      ST_READ: state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy         = (state_r != ST_IDLE);
  assign cmd.load     = (state_r == ST_IDLE) && start;
  assign cmd.rd_other = (state_r == ST_READ);
  assign cmd.exec     = (state_r == ST_EXEC);

endmodule

// ===== rtl/ert_dpath.sv =====
// Datapath of the epoch reclamation tracker: thresholds, global epoch,
// slot mask, announcement and counter memories, result registers. Depends on ert_pkg.
`timescale 1ns / 1ps

module ert_dpath import ert_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  ert_cmd_t           cmd,
  input  logic [1:0]         in_action,
  input  logic [SLOT_W-1:0]  in_thread_id,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata,
  output logic               out_valid,
  output logic [SLOT_W-1:0]  out_slot,
  output logic               out_full_res,
  output logic               out_reclaim,
  output logic [BAG_W-1:0]   out_bag_index,
  output logic [EPOCH_W-1:0] out_epoch_now
);

  // Configuration and global state
  logic [CNT_W-1:0]   chk_thr_r, adv_thr_r;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [SLOTS-1:0]   mask_r, mask_nxt;
  logic [SLOTS-1:0]   ann_vld_r, rec_vld_r;

  // Memories
  logic [EPOCH_W-1:0] ann_mem [SLOTS];
  rec_t               rec_mem [SLOTS];

  // Latched request and read data
  act_t               act_r;
  logic [SLOT_W-1:0]  tid_r;
  logic [EPOCH_W-1:0] ann_a_r, ann_b_r;
  logic               ann_a_v_r, ann_b_v_r;
  rec_t               rec_rd_r;
  logic               rec_v_r;
  logic               new_ep_r;

  // Effective values (entries never written read as zero)
  logic [EPOCH_W-1:0] ann_t, ann_o;
  rec_t               rec_t_q;
  logic               new_ep;
  logic [CNT_W-1:0]   scan_mod;
  logic [SLOT_W-1:0]  other_id;

  // Update logic
  logic               live, is_enter, is_leave, is_reg, is_unreg;
  logic               free_found;
  logic [SLOT_W-1:0]  free_idx;
  logic [BAG_W-1:0]   bag1;
  logic [CNT_W-1:0]   op0, op1, scan0, scan1;
  logic               check, ok_other, adv;
  logic               ann_we, rec_we;
  logic [EPOCH_W-1:0] ann_wdata;
  rec_t               rec_wdata;
  logic [SLOT_W-1:0]  slot_res;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_thr_r <= CNT_W'(32);
      adv_thr_r <= CNT_W'(64);
    end else if (cfg_we) begin
      if (cfg_index == REG_CHECK_THR) chk_thr_r <= cfg_wdata;
      if (cfg_index == REG_ADV_THR)   adv_thr_r <= cfg_wdata;
    end
  end

  // Request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= act_t'(in_action);
      tid_r <= in_thread_id;
    end
  end

  assign ann_t   = ann_a_v_r ? ann_a_r : '0;
  assign ann_o   = ann_b_v_r ? ann_b_r : '0;
  assign rec_t_q = rec_v_r ? rec_rd_r : '0;

  // A new epoch clears the counters before the scan slot is chosen.
  assign new_ep   = (epoch_r != {ann_t[EPOCH_W-1:1], 1'b0});
  assign scan_mod = (new_ep ? '0 : rec_t_q.scan) % CNT_W'(THREADS);
  assign other_id = scan_mod[SLOT_W-1:0];

  // Announcement memory: caller read on load, examined slot read next cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ann_a_r   <= ann_mem[in_thread_id];
      ann_a_v_r <= ann_vld_r[in_thread_id];
    end
    if (cmd.rd_other) begin
      ann_b_r   <= ann_mem[other_id];
      ann_b_v_r <= ann_vld_r[other_id];
      new_ep_r  <= new_ep;
    end
    if (ann_we) begin
      ann_mem[tid_r] <= ann_wdata;
    end
  end

  // Counter memory
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rec_rd_r <= rec_mem[in_thread_id];
      rec_v_r  <= rec_vld_r[in_thread_id];
    end
    if (rec_we) begin
      rec_mem[tid_r] <= rec_wdata;
    end
  end

  // Lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = THREADS - 1; i >= 0; i--) begin
      if (!mask_r[SLOT_W'(i)]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  assign is_reg   = (act_r == ACT_REGISTER);
  assign is_unreg = (act_r == ACT_UNREGISTER);
  assign is_enter = (act_r == ACT_ENTER);
  assign is_leave = (act_r == ACT_LEAVE);
  assign live     = ({1'b0, tid_r} < (SLOT_W + 1)'(THREADS)) && mask_r[tid_r];

  always_comb begin
    op0   = new_ep_r ? '0 : rec_t_q.op;
    scan0 = new_ep_r ? '0 : rec_t_q.scan;
    if (new_ep_r) begin
      bag1 = (rec_t_q.bag >= BAG_W'(BAG_COUNT - 1)) ? '0 : rec_t_q.bag + BAG_W'(1);
    end else begin
      bag1 = rec_t_q.bag;
    end
    op1      = sat_inc(op0);
    check    = (op1 >= chk_thr_r);
    ok_other = (epoch_r == {ann_o[EPOCH_W-1:1], 1'b0}) || ann_o[0];
    scan1    = (check && ok_other) ? sat_inc(scan0) : scan0;
    adv      = check && ok_other && (scan1 >= CNT_W'(THREADS)) && (scan1 >= adv_thr_r);

    rec_we          = cmd.exec && is_enter && live;
    rec_wdata.bag   = bag1;
    rec_wdata.op    = check ? '0 : op1;
    rec_wdata.scan  = scan1;

    ann_we    = cmd.exec && live && (is_enter || is_leave);
    ann_wdata = is_enter ? epoch_r : (ann_t | EPOCH_W'(1));

    epoch_nxt = epoch_r;
    if (is_enter && live && adv) epoch_nxt = epoch_r + EPOCH_W'(EPOCH_STEP);

    mask_nxt = mask_r;
    slot_res = tid_r;
    if (is_reg) begin
      slot_res = free_found ? free_idx : '0;
      if (free_found) mask_nxt[free_idx] = 1'b1;
    end else if (is_unreg && live) begin
      mask_nxt[tid_r] = 1'b0;
    end
  end

  // State update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r   <= '0;
      mask_r    <= '0;
      ann_vld_r <= '0;
      rec_vld_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.exec;
      if (cmd.exec) begin
        epoch_r <= epoch_nxt;
        mask_r  <= mask_nxt;
        if (ann_we) ann_vld_r[tid_r] <= 1'b1;
        if (rec_we) rec_vld_r[tid_r] <= 1'b1;
        // a fresh registration starts with cleared counters
        if (is_reg && free_found) rec_vld_r[free_idx] <= 1'b0;
      end
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_slot      <= slot_res;
      out_full_res  <= is_reg && !free_found;
      out_reclaim   <= is_enter && live && new_ep_r;
      out_bag_index <= (is_enter && live && new_ep_r) ? bag1 : '0;
      out_epoch_now <= epoch_nxt;
    end
  end

endmodule

// ===== rtl/epoch_reclamation_tracker.sv =====
// Top level of the epoch reclamation tracker: controller plus datapath.
// Depends on ert_pkg, ert_ctrl, ert_dpath and assert_macros.svh.
//
//   channel   | handshake            | payload
//   ----------+----------------------+---------------------------------------
//   request   | start / busy         | in_action, in_thread_id
//   result    | out_valid (strobe)   | out_slot, out_full_res, out_reclaim,
//             |                      | out_bag_index, out_epoch_now
//   config    | cfg_we               | cfg_index, cfg_wdata
//
// A request passes through read of the caller's announcement and counters,
// read of the examined slot's announcement (addressed by the caller's scan
// count), then the update. The result strobes in the cycle after, when busy
// is already low and the next request may be taken. Reset needs no clearing
// pass: per-slot valid bits make unwritten entries read as zero. Results
// cannot be held off by the receiver.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module epoch_reclamation_tracker import ert_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_action,
  input  logic [SLOT_W-1:0]  in_thread_id,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata,
  output logic               out_valid,
  output logic [SLOT_W-1:0]  out_slot,
  output logic               out_full_res,
  output logic               out_reclaim,
  output logic [BAG_W-1:0]   out_bag_index,
  output logic [EPOCH_W-1:0] out_epoch_now
);

  ert_cmd_t cmd;

  ert_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  ert_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_action     (in_action),
    .in_thread_id  (in_thread_id),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (out_valid),
    .out_slot      (out_slot),
    .out_full_res  (out_full_res),
    .out_reclaim   (out_reclaim),
    .out_bag_index (out_bag_index),
    .out_epoch_now (out_epoch_now)
  );

  `AST_NEXT(a_exec_follows_read, cmd.rd_other, cmd.exec && busy, "update did not follow the read")
  `AST_HOLDS(a_result_when_idle, !out_valid || !busy, "result strobed while a request is in flight")
  `AST_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe lasted more than one cycle")
  `AST_HOLDS(a_epoch_even, !out_valid || !out_epoch_now[0], "reported epoch is odd")

endmodule
